>>> src/ordered_list_table_engine_unit_macros.svh
`ifndef ORDERED_LIST_TABLE_ENGINE_UNIT_MACROS_SVH
`define ORDERED_LIST_TABLE_ENGINE_UNIT_MACROS_SVH

// Same-cycle implication, checked on clk, muted while rst is high
`define OLTE_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked on clk, muted while rst is high
`define OLTE_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> src/olte_pkg.sv
`timescale 1ns / 1ps

package olte_pkg;

  // Position field width is fixed by the request format
  localparam int POS_W = 9;

  typedef enum logic [1:0] {
    CMD_INSERT = 2'd0,
    CMD_ERASE  = 2'd1,
    CMD_FIND   = 2'd2,
    CMD_MODIFY = 2'd3
  } cmd_t;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_RANGE = 2'd1,
    ST_FULL  = 2'd2,
    ST_MISS  = 2'd3
  } status_t;

  // Broadcast to every cell; enables are already qualified by the checks
  typedef struct packed {
    logic             ins;
    logic             ers;
    logic             mod;
    logic [POS_W-1:0] pos;
  } cell_ctrl_t;

endpackage

>>> src/ordered_list_table_engine_unit.sv
`timescale 1ns / 1ps
// Insert, erase and modify: result registered in the cycle after the request is taken;
// a new request can be taken every cycle while the result side keeps draining.
// Find: result loaded once the search has passed the per-cell compare register and the
// registered priority tree and the result side is free; input is held off meanwhile.
// Reset clears the entry count and the result valid flag; entries are not cleared.

module ordered_list_table_engine_unit #(
  parameter int DEPTH      = 256,
  parameter int DATA_WIDTH = 32
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_ready,
  input  olte_pkg::cmd_t    cmd,
  input  logic [8:0]        position,
  input  logic [31:0]       value,
  output logic              out_valid,
  input  logic              out_ready,
  output olte_pkg::status_t status,
  output logic [7:0]        found_index,
  output logic [8:0]        count
);
  import olte_pkg::*;

  `include "ordered_list_table_engine_unit_macros.svh"

  localparam int CW = $clog2(DEPTH + 1);
  localparam int IW = $clog2(DEPTH);
  localparam int SW = $clog2(IW + 2);
  localparam int XW = CW + POS_W;

  typedef enum logic {
    S_IDLE,
    S_SEARCH
  } state_t;

  state_t          state;
  logic [CW-1:0]   used_count;
  logic [CW-1:0]   used_count_next;
  logic [SW-1:0]   wait_cnt;
  logic [DATA_WIDTH-1:0] key;
  logic [DATA_WIDTH-1:0] word;
  logic [63:0]     value_x;
  logic [XW-1:0]   pos_x;
  logic [XW-1:0]   cnt_x;
  logic            accept;
  logic            out_free;
  logic            res_load;
  logic            do_ins;
  logic            do_ers;
  logic            do_mod;
  status_t         st_now;
  cell_ctrl_t      ctrl;
  logic            root_hit;
  logic [IW-1:0]   root_idx;
  logic [IW+7:0]   fidx_x;
  logic [CW+8:0]   count_x;
  logic [DEPTH-1:0] cell_hit;
  logic [DATA_WIDTH-1:0] cell_data  [DEPTH];
  logic [DATA_WIDTH-1:0] cell_left  [DEPTH];
  logic [DATA_WIDTH-1:0] cell_right [DEPTH];

  // Keep the low DATA_WIDTH bits of the 32-bit request word
  assign value_x = {32'd0, value};
  assign word    = value_x[DATA_WIDTH-1:0];

  assign pos_x = {{CW{1'b0}}, position};
  assign cnt_x = {{POS_W{1'b0}}, used_count};

  assign out_free = !out_valid || out_ready;
  assign in_ready = (state == S_IDLE) && out_free;
  assign accept   = in_valid && in_ready;

  // A result is loaded when a non-find request is taken or a search completes
  assign res_load = (state == S_IDLE)
                    ? (accept && (cmd != CMD_FIND))
                    : ((wait_cnt == '0) && out_free);

  // Range and fullness checks
  always_comb begin
    do_ins = 1'b0;
    do_ers = 1'b0;
    do_mod = 1'b0;
    st_now = ST_OK;
    case (cmd)
      CMD_INSERT: begin
        if (pos_x > cnt_x) begin
          st_now = ST_RANGE;
        end else if (used_count == CW'(DEPTH)) begin
          st_now = ST_FULL;
        end else begin
          do_ins = 1'b1;
        end
      end
      CMD_ERASE: begin
        if (pos_x >= cnt_x) begin
          st_now = ST_RANGE;
        end else begin
          do_ers = 1'b1;
        end
      end
      CMD_MODIFY: begin
        if (pos_x >= cnt_x) begin
          st_now = ST_RANGE;
        end else begin
          do_mod = 1'b1;
        end
      end
      CMD_FIND: begin
        st_now = ST_OK;
      end
      default: begin
        st_now = ST_RANGE;
      end
    endcase
  end

  assign ctrl.ins = accept && do_ins;
  assign ctrl.ers = accept && do_ers;
  assign ctrl.mod = accept && do_mod;
  assign ctrl.pos = position;

  always_comb begin
    used_count_next = used_count;
    if (ctrl.ins) begin
      used_count_next = used_count + CW'(1);
    end else if (ctrl.ers) begin
      used_count_next = used_count - CW'(1);
    end
  end

  assign count_x = {9'd0, used_count_next};
  assign fidx_x  = {8'd0, root_idx};

  // Row of entry cells, each passing its word to both neighbours
  for (genvar g = 0; g < DEPTH; g++) begin : g_cell
    if (g == 0) begin : g_first
      assign cell_left[g] = cell_data[g];
    end else begin : g_mid_l
      assign cell_left[g] = cell_data[g-1];
    end
    if (g == DEPTH - 1) begin : g_last
      assign cell_right[g] = cell_data[g];
    end else begin : g_mid_r
      assign cell_right[g] = cell_data[g+1];
    end

    olte_cell #(
      .DW  (DATA_WIDTH),
      .IW  (IW),
      .CW  (CW),
      .IDX (g)
    ) u_cell (
      .clk   (clk),
      .ctrl  (ctrl),
      .count (used_count),
      .key   (key),
      .word  (word),
      .left  (cell_left[g]),
      .right (cell_right[g]),
      .data  (cell_data[g]),
      .hit   (cell_hit[g])
    );
  end

  olte_find_tree #(
    .N  (DEPTH),
    .IW (IW)
  ) u_tree (
    .clk      (clk),
    .hit      (cell_hit),
    .root_hit (root_hit),
    .root_idx (root_idx)
  );

  // Control, list count and result register
  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      used_count <= '0;
      wait_cnt   <= '0;
      out_valid  <= 1'b0;
    end else begin
      used_count <= used_count_next;
      out_valid  <= res_load || (out_valid && !out_ready);
      case (state)
        S_IDLE: begin
          if (accept) begin
            if (cmd == CMD_FIND) begin
              key      <= word;
              wait_cnt <= SW'(IW + 1);
              state    <= S_SEARCH;
            end else begin
              status      <= st_now;
              found_index <= 8'd0;
              count       <= count_x[8:0];
            end
          end
        end
        S_SEARCH: begin
          if (wait_cnt != '0) begin
            wait_cnt <= wait_cnt - SW'(1);
          end else if (out_free) begin
            status      <= root_hit ? ST_OK : ST_MISS;
            found_index <= root_hit ? fidx_x[7:0] : 8'd0;
            count       <= count_x[8:0];
            state       <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  `OLTE_ASSERT_NOW(a_count_bound, 1'b1, used_count <= CW'(DEPTH), "list count above depth")
  `OLTE_ASSERT_NOW(a_no_take_in_search, state == S_SEARCH, !in_ready, "request taken mid-search")
  `OLTE_ASSERT_NOW(a_full_flag, out_valid && status == ST_FULL, count == 9'(DEPTH), "bad full flag")
  `OLTE_ASSERT_NEXT(a_erase_dec, ctrl.ers, used_count == $past(used_count) - CW'(1), "bad erase")
  `OLTE_ASSERT_NEXT(a_insert_inc, ctrl.ins, used_count == $past(used_count) + CW'(1), "bad insert")

endmodule

>>> src/olte_cell.sv
`timescale 1ns / 1ps

module olte_cell #(
  parameter int DW  = 32,
  parameter int IW  = 8,
  parameter int CW  = 9,
  parameter int IDX = 0
) (
  input  logic               clk,
  input  olte_pkg::cell_ctrl_t ctrl,
  input  logic [CW-1:0]      count,
  input  logic [DW-1:0]      key,
  input  logic [DW-1:0]      word,
  input  logic [DW-1:0]      left,
  input  logic [DW-1:0]      right,
  output logic [DW-1:0]      data,
  output logic               hit
);
  import olte_pkg::*;

  localparam int XW = IW + POS_W;

  logic [XW-1:0] pos_x;
  logic [XW-1:0] idx_x;
  logic [DW-1:0] data_next;

  assign pos_x = {{IW{1'b0}}, ctrl.pos};
  assign idx_x = XW'(IDX);

  // Shift up on insert, down on erase, overwrite on modify
  always_comb begin
    data_next = data;
    if (ctrl.ins) begin
      if (idx_x > pos_x) begin
        data_next = left;
      end else if (idx_x == pos_x) begin
        data_next = word;
      end
    end else if (ctrl.ers) begin
      if (idx_x >= pos_x) begin
        data_next = right;
      end
    end else if (ctrl.mod) begin
      if (idx_x == pos_x) begin
        data_next = word;
      end
    end
  end

  always_ff @(posedge clk) begin
    data <= data_next;
    // Match only counts for entries inside the list
    hit  <= (CW'(IDX) < count) && (data == key);
  end

endmodule

>>> src/olte_find_tree.sv
`timescale 1ns / 1ps

module olte_find_tree #(
  parameter int N  = 256,
  parameter int IW = 8
) (
  input  logic          clk,
  input  logic [N-1:0]  hit,
  output logic          root_hit,
  output logic [IW-1:0] root_idx
);

  localparam int NP = 1 << IW;

  // Heap layout: node k has children 2k and 2k+1, leaves from NP upward
  logic          node_hit [1:2*NP-1];
  logic [IW-1:0] node_idx [1:2*NP-1];

  for (genvar k = 0; k < NP; k++) begin : g_leaf
    if (k < N) begin : g_real
      assign node_hit[NP+k] = hit[k];
    end else begin : g_pad
      assign node_hit[NP+k] = 1'b0;
    end
    assign node_idx[NP+k] = IW'(k);
  end

  // One register per inner node; the lower index wins on a tie
  for (genvar k = 1; k < NP; k++) begin : g_node
    always_ff @(posedge clk) begin
      node_hit[k] <= node_hit[2*k] | node_hit[2*k+1];
      node_idx[k] <= node_hit[2*k] ? node_idx[2*k] : node_idx[2*k+1];
    end
  end

  assign root_hit = node_hit[1];
  assign root_idx = node_idx[1];

endmodule

>>> dv/ordered_list_table_engine_unit_tb.sv
`timescale 1ns / 1ps

module ordered_list_table_engine_unit_tb;
  import olte_pkg::*;

  localparam int DEPTH = 256;

  // One result word as the block reports it
  typedef struct {
    status_t    st;
    logic [7:0] idx;
    logic [8:0] cnt;
  } list_result_t;

  // Shadow copy of the ordered list; works out the result of every request
  class list_shadow;
    logic [31:0]  words [DEPTH];
    int           used;
    int           errors;
    list_result_t expected_results [$];

    function new();
      used   = 0;
      errors = 0;
    endfunction

    function void apply_request(cmd_t op, logic [8:0] pos, logic [31:0] word);
      list_result_t r;
      int           i;
      r.st  = ST_OK;
      r.idx = 8'd0;
      case (op)
        CMD_INSERT: begin
          if (int'(pos) > used) r.st = ST_RANGE;
          else if (used >= DEPTH) r.st = ST_FULL;
          else begin
            for (i = used; i > int'(pos); i--) words[i] = words[i-1];
            words[pos] = word;
            used++;
          end
        end
        CMD_ERASE: begin
          if (int'(pos) >= used) r.st = ST_RANGE;
          else begin
            for (i = int'(pos) + 1; i < used; i++) words[i-1] = words[i];
            used--;
          end
        end
        CMD_FIND: begin
          r.st = ST_MISS;
          for (i = 0; i < used; i++) begin
            if (words[i] == word) begin
              r.st  = ST_OK;
              r.idx = 8'(i);
              break;
            end
          end
        end
        default: begin
          if (int'(pos) >= used) r.st = ST_RANGE;
          else words[pos] = word;
        end
      endcase
      r.cnt = 9'(used);
      expected_results.push_back(r);
    endfunction

    function void check_result(status_t st, logic [7:0] idx, logic [8:0] cnt);
      list_result_t r;
      if (expected_results.size() == 0) begin
        $display("%0t: unexpected result: status %0d found_index %0d count %0d",
                 $time, st, idx, cnt);
        errors++;
        return;
      end
      r = expected_results.pop_front();
      if (st !== r.st) begin
        $display("%0t: status mismatch: expected %0d actual %0d", $time, r.st, st);
        errors++;
      end
      if (idx !== r.idx) begin
        $display("%0t: found_index mismatch: expected %0d actual %0d", $time, r.idx, idx);
        errors++;
      end
      if (cnt !== r.cnt) begin
        $display("%0t: count mismatch: expected %0d actual %0d", $time, r.cnt, cnt);
        errors++;
      end
    endfunction
  endclass

  logic       clk = 1'b0;
  logic       rst;
  logic       in_valid;
  logic       in_ready;
  cmd_t       cmd;
  logic [8:0] position;
  logic [31:0] value;
  logic       out_valid;
  logic       out_ready;
  status_t    status;
  logic [7:0] found_index;
  logic [8:0] count;

  list_shadow shadow = new();
  int         sent;
  bit         calm_sender;

  ordered_list_table_engine_unit #(
    .DEPTH(DEPTH),
    .DATA_WIDTH(32)
  ) dut (
    .clk(clk),
    .rst(rst),
    .in_valid(in_valid),
    .in_ready(in_ready),
    .cmd(cmd),
    .position(position),
    .value(value),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .status(status),
    .found_index(found_index),
    .count(count)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // Idle length: mostly none or short, now and then long
  function automatic int pick_gap();
    int r;
    r = $urandom_range(99);
    if (r < 55) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  function automatic logic [31:0] corner_word();
    case ($urandom_range(6))
      0: return 32'h8000_0000;
      1: return 32'h7fff_ffff;
      2: return 32'hffff_ffff;
      3: return 32'h0000_0000;
      4: return 32'h0000_0001;
      5: return 32'h5555_5555;
      default: return 32'haaaa_aaaa;
    endcase
  endfunction

  // Words drawn partly from the list itself so that finds hit and duplicates appear
  function automatic logic [31:0] pick_word();
    int r;
    r = $urandom_range(99);
    if (r < 45 && shadow.used > 0) return shadow.words[$urandom_range(shadow.used - 1)];
    if (r < 65) return corner_word();
    return $urandom;
  endfunction

  // Present one request at the falling edge, hold it until taken, then maybe idle
  task automatic issue_request(cmd_t op, logic [8:0] pos, logic [31:0] word);
    int gap;
    in_valid = 1'b1;
    cmd      = op;
    position = pos;
    value    = word;
    do @(posedge clk); while (!in_ready);
    shadow.apply_request(op, pos, word);
    sent++;
    if (sent % 50 == 0) calm_sender = ($urandom_range(3) == 0);
    @(negedge clk);
    gap = calm_sender ? 0 : pick_gap();
    if (gap > 0) begin
      in_valid = 1'b0;
      repeat (gap) @(negedge clk);
    end
  endtask

  // Random request with a bias towards growing or shrinking the list
  task automatic random_request(int ins_pct, int ers_pct);
    cmd_t       op;
    logic [8:0] pos;
    int         r;
    int         top;
    r = $urandom_range(99);
    if (r < ins_pct) op = CMD_INSERT;
    else if (r < ins_pct + ers_pct) op = CMD_ERASE;
    else op = ($urandom_range(1) == 0) ? CMD_FIND : CMD_MODIFY;
    top = (op == CMD_INSERT) ? shadow.used : shadow.used - 1;
    r = $urandom_range(99);
    if (op == CMD_FIND || top < 0 || r < 12) pos = 9'($urandom_range(511));
    else if (r < 35) pos = 9'd0;
    else if (r < 58) pos = 9'(top);
    else pos = 9'($urandom_range(top));
    issue_request(op, pos, pick_word());
  endtask

  // Result side: random stalls, with calm stretches
  initial begin
    int  stall_left;
    int  cyc;
    bit  steady;
    stall_left = 0;
    cyc        = 0;
    steady     = 1'b0;
    out_ready  = 1'b0;
    forever begin
      @(negedge clk);
      cyc++;
      if (cyc % 150 == 0) steady = ($urandom_range(3) == 0);
      if (stall_left > 0) begin
        out_ready = 1'b0;
        stall_left--;
      end else begin
        out_ready = 1'b1;
        if (!steady && $urandom_range(99) < 30) stall_left = pick_gap();
      end
    end
  end

  // Every result taken is checked against the oldest expectation
  always @(posedge clk) begin
    if (!rst && out_valid && out_ready) shadow.check_result(status, found_index, count);
  end

  initial begin
    #6_000_000;
    $display("Simulation FAILED");
    $finish;
  end

  initial begin
    rst         = 1'b1;
    in_valid    = 1'b0;
    cmd         = CMD_INSERT;
    position    = 9'd0;
    value       = 32'd0;
    sent        = 0;
    calm_sender = 1'b0;
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // Empty list: everything but an append is out of range, find misses
    issue_request(CMD_ERASE, 9'd0, 32'd0);
    issue_request(CMD_MODIFY, 9'd0, 32'd7);
    issue_request(CMD_FIND, 9'd0, 32'd0);
    issue_request(CMD_INSERT, 9'd1, 32'd3);
    // Build -1, 0, min, max through append, front and middle inserts
    issue_request(CMD_INSERT, 9'd0, 32'h8000_0000);
    issue_request(CMD_INSERT, 9'd1, 32'h7fff_ffff);
    issue_request(CMD_INSERT, 9'd0, 32'hffff_ffff);
    issue_request(CMD_INSERT, 9'd1, 32'h0000_0000);
    issue_request(CMD_FIND, 9'd511, 32'h7fff_ffff);
    issue_request(CMD_FIND, 9'd0, 32'hffff_ffff);
    issue_request(CMD_FIND, 9'd3, 32'h1234_5678);
    // Duplicate word: find must report the first one
    issue_request(CMD_MODIFY, 9'd3, 32'hffff_ffff);
    issue_request(CMD_FIND, 9'd0, 32'hffff_ffff);
    // Positions at and beyond the end
    issue_request(CMD_MODIFY, 9'd4, 32'd1);
    issue_request(CMD_ERASE, 9'd4, 32'd0);
    issue_request(CMD_ERASE, 9'd511, 32'd0);
    issue_request(CMD_INSERT, 9'd511, 32'd9);
    issue_request(CMD_INSERT, 9'd4, 32'h5555_5555);
    // Pop front, pop back, erase from the middle, then drain
    issue_request(CMD_ERASE, 9'd0, 32'd0);
    issue_request(CMD_ERASE, 9'd3, 32'd0);
    issue_request(CMD_ERASE, 9'd1, 32'd0);
    issue_request(CMD_MODIFY, 9'd0, 32'haaaa_aaaa);
    issue_request(CMD_ERASE, 9'd1, 32'd0);
    issue_request(CMD_ERASE, 9'd0, 32'd0);

    // Grow to full, then lean on the full list
    while (shadow.used < DEPTH) random_request(85, 5);
    issue_request(CMD_INSERT, 9'd256, 32'd5);
    issue_request(CMD_INSERT, 9'd257, 32'd5);
    issue_request(CMD_FIND, 9'd0, shadow.words[DEPTH-1]);
    repeat (20) random_request(70, 0);
    // Churn, shrink to empty, churn again
    repeat (70) random_request(35, 35);
    while (shadow.used > 0) random_request(5, 85);
    repeat (10) random_request(0, 60);
    repeat (50) random_request(30, 30);
    in_valid = 1'b0;

    while (shadow.expected_results.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
    if (shadow.errors == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
